FILE: rtl/core/multi_button_debounce_dispatch_core_assert.svh
`ifndef MULTI_BUTTON_DEBOUNCE_DISPATCH_CORE_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCE_DISPATCH_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define MBDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// next-cycle implication, off during reset
`define MBDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

FILE: rtl/core/mbdd_pkg.sv
package mbdd_pkg;

    localparam int BTN_W   = 8;
    localparam int NOW_W   = 32;
    localparam int DELAY_W = 16;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd30;

    localparam int BTN_ZERO  = 0;
    localparam int BTN_RAISE = 1;
    localparam int BTN_LOWER = 2;
    localparam int BTN_WHEEL = 3;
    localparam int BTN_TROT  = 4;
    localparam int BTN_WALK  = 5;

    localparam logic GAIT_TROT = 1'b0;
    localparam logic GAIT_WALK = 1'b1;

    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_ZERO,
        REQ_RAISE,
        REQ_LOWER
    } t_req;

    typedef struct packed {
        logic press;
        logic stable;
    } t_lane_out;

    typedef struct packed {
        t_req req;
        logic wheel;
        logic gait;
        logic changed;
    } t_mode;

endpackage

FILE: rtl/core/mbdd_if.sv
interface mbdd_in_if;
    logic                         valid;
    logic                         ready;
    logic [mbdd_pkg::BTN_W-1:0]   button_levels;
    logic [mbdd_pkg::NOW_W-1:0]   now_ms;

    modport source (output valid, output button_levels, output now_ms, input ready);
    modport sink   (input valid, input button_levels, input now_ms, output ready);
endinterface

interface mbdd_out_if;
    logic                         valid;
    logic                         ready;
    logic [mbdd_pkg::BTN_W-1:0]   press_events;
    logic [mbdd_pkg::BTN_W-1:0]   stable_levels;
    logic                         zero_request;
    logic                         raise_request;
    logic                         lower_request;
    logic                         wheel_mode;
    logic                         gait_mode;
    logic                         gait_changed;

    modport source (output valid, output press_events, output stable_levels,
                    output zero_request, output raise_request, output lower_request,
                    output wheel_mode, output gait_mode, output gait_changed,
                    input ready);
    modport sink   (input valid, input press_events, input stable_levels,
                    input zero_request, input raise_request, input lower_request,
                    input wheel_mode, input gait_mode, input gait_changed,
                    output ready);
endinterface

interface mbdd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbdd_pkg::DELAY_W-1:0]   debounce_delay;

    modport source (output valid, output debounce_delay, input ready);
    modport sink   (input valid, input debounce_delay, output ready);
endinterface

FILE: rtl/core/multi_button_debounce_dispatch_core.sv
// channel    dir   beat payload
// i_sample   in    button_levels[7:0], now_ms[31:0]
// o_result   out   press_events, stable_levels, requests, wheel_mode, gait_mode, gait_changed
// i_cfg      in    debounce_delay[15:0], ready always high
//
// one sample per cycle while ready; the result appears in the cycle after its beat is taken
// per-button lanes compare age against the delay, then one merge stage sets modes
// the output register frees a slot whenever the result beat is taken
// synchronous active-low reset clears all levels, timers, modes; delay back to 30
module multi_button_debounce_dispatch_core #(
    parameter int BUTTON_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbdd_in_if.sink           i_sample,
    mbdd_out_if.source        o_result,
    mbdd_cfg_if.sink          i_cfg
);

    localparam int LaneCount = (BUTTON_COUNT < mbdd_pkg::BTN_W) ? BUTTON_COUNT
                                                                 : mbdd_pkg::BTN_W;

    logic [mbdd_pkg::DELAY_W-1:0]   r_delay;
    logic                           r_wheel;
    logic                           r_gait;
    logic                           r_out_valid;
    logic [mbdd_pkg::BTN_W-1:0]     r_press;
    logic [mbdd_pkg::BTN_W-1:0]     r_stable;
    mbdd_pkg::t_mode                r_mode;

    logic                           w_take;
    logic [mbdd_pkg::BTN_W-1:0]     w_press;
    logic [mbdd_pkg::BTN_W-1:0]     w_stable;
    mbdd_pkg::t_mode                w_mode;

    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign w_take         = i_sample.valid && i_sample.ready;
    assign i_cfg.ready    = 1'b1;

    for (genvar gi = 0; gi < mbdd_pkg::BTN_W; gi++) begin : g_lane
        if (gi < LaneCount) begin : g_on
            mbdd_pkg::t_lane_out w_lane;

            mbdd_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_take  (w_take),
                .i_level (i_sample.button_levels[gi]),
                .i_now   (i_sample.now_ms),
                .i_delay (r_delay),
                .o_lane  (w_lane)
            );

            assign w_press[gi]  = w_lane.press;
            assign w_stable[gi] = w_lane.stable;
        end else begin : g_off
            assign w_press[gi]  = 1'b0;
            assign w_stable[gi] = 1'b0;
        end
    end

    mbdd_merge u_merge (
        .i_press (w_press),
        .i_wheel (r_wheel),
        .i_gait  (r_gait),
        .o_mode  (w_mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= mbdd_pkg::DELAY_RESET;
            r_wheel     <= 1'b0;
            r_gait      <= mbdd_pkg::GAIT_TROT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_delay <= i_cfg.debounce_delay;
            end
            if (w_take) begin
                r_wheel     <= w_mode.wheel;
                r_gait      <= w_mode.gait;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_press  <= w_press;
            r_stable <= w_stable;
            r_mode   <= w_mode;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.press_events  = r_press;
    assign o_result.stable_levels = r_stable;
    assign o_result.zero_request  = (r_mode.req == mbdd_pkg::REQ_ZERO);
    assign o_result.raise_request = (r_mode.req == mbdd_pkg::REQ_RAISE);
    assign o_result.lower_request = (r_mode.req == mbdd_pkg::REQ_LOWER);
    assign o_result.wheel_mode    = r_mode.wheel;
    assign o_result.gait_mode     = r_mode.gait;
    assign o_result.gait_changed  = r_mode.changed;

endmodule

FILE: rtl/core/mbdd_lane.sv
module mbdd_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic                           i_level,
    input  logic [mbdd_pkg::NOW_W-1:0]     i_now,
    input  logic [mbdd_pkg::DELAY_W-1:0]   i_delay,
    output mbdd_pkg::t_lane_out            o_lane
);

    logic                         r_prev;
    logic                         r_stable;
    logic [mbdd_pkg::NOW_W-1:0]   r_stamp;
    logic [mbdd_pkg::NOW_W-1:0]   w_age;
    logic                         w_fire;
    logic                         n_stable;

    // a raw change restarts the timer, so it can never fire in the same beat
    assign w_age    = i_now - r_stamp;
    assign w_fire   = (i_level == r_prev) && (i_level != r_stable)
                      && (w_age > {{(mbdd_pkg::NOW_W-mbdd_pkg::DELAY_W){1'b0}}, i_delay});
    assign n_stable = w_fire ? i_level : r_stable;

    assign o_lane.press  = w_fire && i_level;
    assign o_lane.stable = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b0;
            r_stable <= 1'b0;
            r_stamp  <= '0;
        end else if (i_take) begin
            r_prev   <= i_level;
            r_stable <= n_stable;
            if (i_level != r_prev) begin
                r_stamp <= i_now;
            end
        end
    end

endmodule

FILE: rtl/core/mbdd_merge.sv
module mbdd_merge (
    input  logic [mbdd_pkg::BTN_W-1:0]   i_press,
    input  logic                         i_wheel,
    input  logic                         i_gait,
    output mbdd_pkg::t_mode              o_mode
);

    // later button index overrides earlier ones
    always_comb begin
        o_mode.req     = mbdd_pkg::REQ_NONE;
        o_mode.wheel   = i_wheel;
        o_mode.gait    = i_gait;
        o_mode.changed = 1'b0;
        if (i_press[mbdd_pkg::BTN_ZERO]) begin
            o_mode.req = mbdd_pkg::REQ_ZERO;
        end
        if (i_press[mbdd_pkg::BTN_RAISE]) begin
            o_mode.req = mbdd_pkg::REQ_RAISE;
        end
        if (i_press[mbdd_pkg::BTN_LOWER]) begin
            o_mode.req = mbdd_pkg::REQ_LOWER;
        end
        if (i_press[mbdd_pkg::BTN_WHEEL]) begin
            o_mode.wheel = !i_wheel;
            if (!i_wheel) begin
                o_mode.req = mbdd_pkg::REQ_ZERO;
            end else begin
                o_mode.gait    = mbdd_pkg::GAIT_TROT;
                o_mode.changed = 1'b1;
            end
        end
        if (i_press[mbdd_pkg::BTN_TROT] && (o_mode.gait != mbdd_pkg::GAIT_TROT)) begin
            o_mode.gait    = mbdd_pkg::GAIT_TROT;
            o_mode.changed = 1'b1;
        end
        if (i_press[mbdd_pkg::BTN_WALK] && (o_mode.gait != mbdd_pkg::GAIT_WALK)) begin
            o_mode.gait    = mbdd_pkg::GAIT_WALK;
            o_mode.changed = 1'b1;
        end
    end

endmodule

FILE: rtl/core/mbdd_checker.sv
`include "multi_button_debounce_dispatch_core_assert.svh"

module mbdd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_ready,
    input  logic [mbdd_pkg::BTN_W-1:0]   i_press,
    input  logic [mbdd_pkg::BTN_W-1:0]   i_stable,
    input  logic                         i_zero,
    input  logic                         i_raise,
    input  logic                         i_lower,
    input  logic                         i_wheel,
    input  logic                         i_gait,
    input  logic                         i_changed
);

    `MBDD_ASSERT_NOW(a_one_request, i_clk, i_rst_n, i_valid,
        $countones({i_zero, i_raise, i_lower}) <= 1)

    `MBDD_ASSERT_NOW(a_press_is_stable, i_clk, i_rst_n, i_valid,
        (i_press & ~i_stable) == '0)

    `MBDD_ASSERT_NOW(a_zero_source, i_clk, i_rst_n, i_valid && i_zero,
        i_press[mbdd_pkg::BTN_ZERO] || (i_press[mbdd_pkg::BTN_WHEEL] && i_wheel))

    `MBDD_ASSERT_NOW(a_gait_source, i_clk, i_rst_n, i_valid && i_changed,
        i_press[mbdd_pkg::BTN_WHEEL] || i_press[mbdd_pkg::BTN_TROT]
        || i_press[mbdd_pkg::BTN_WALK])

    `MBDD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready,
        i_valid && $stable({i_press, i_stable, i_zero, i_raise, i_lower,
                            i_wheel, i_gait, i_changed}))

endmodule

bind multi_button_debounce_dispatch_core mbdd_checker u_mbdd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_result.valid),
    .i_ready   (o_result.ready),
    .i_press   (o_result.press_events),
    .i_stable  (o_result.stable_levels),
    .i_zero    (o_result.zero_request),
    .i_raise   (o_result.raise_request),
    .i_lower   (o_result.lower_request),
    .i_wheel   (o_result.wheel_mode),
    .i_gait    (o_result.gait_mode),
    .i_changed (o_result.gait_changed)
);

FILE: test/debounce_dispatch_checker.sv
module debounce_dispatch_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mbdd_in_if   i_sample,
    mbdd_out_if  i_result,
    mbdd_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mbdd_pkg::BTN_W-1:0] press;
        logic [mbdd_pkg::BTN_W-1:0] stable;
        logic                       zero;
        logic                       raise;
        logic                       lower;
        logic                       wheel;
        logic                       gait;
        logic                       changed;
    } t_dispatch;

    logic [mbdd_pkg::DELAY_W-1:0] delay_q;
    logic [mbdd_pkg::BTN_W-1:0]   raw_q;
    logic [mbdd_pkg::BTN_W-1:0]   stable_q;
    logic [mbdd_pkg::NOW_W-1:0]   stamp_q [mbdd_pkg::BTN_W];
    logic                         wheel_q;
    logic                         gait_q;
    t_dispatch                    expected_dispatch [$];
    int                           fail_count = 0;

    assign o_errors = fail_count;

    function automatic t_dispatch debounce_and_dispatch(
        input logic [mbdd_pkg::BTN_W-1:0] lv,
        input logic [mbdd_pkg::NOW_W-1:0] ts
    );
        t_dispatch                  d;
        mbdd_pkg::t_req             slot;
        logic [mbdd_pkg::NOW_W-1:0] age;
        d    = '0;
        slot = mbdd_pkg::REQ_NONE;
        for (int b = 0; b < mbdd_pkg::BTN_W; b++) begin
            if (lv[b] != raw_q[b]) begin
                stamp_q[b] = ts;
            end
            age = ts - stamp_q[b];
            if (age > {{(mbdd_pkg::NOW_W-mbdd_pkg::DELAY_W){1'b0}}, delay_q}
                && lv[b] != stable_q[b]) begin
                stable_q[b] = lv[b];
                if (lv[b]) begin
                    d.press[b] = 1'b1;
                    case (b)
                        mbdd_pkg::BTN_ZERO:  slot = mbdd_pkg::REQ_ZERO;
                        mbdd_pkg::BTN_RAISE: slot = mbdd_pkg::REQ_RAISE;
                        mbdd_pkg::BTN_LOWER: slot = mbdd_pkg::REQ_LOWER;
                        mbdd_pkg::BTN_WHEEL: begin
                            wheel_q = ~wheel_q;
                            if (wheel_q) begin
                                slot = mbdd_pkg::REQ_ZERO;
                            end else begin
                                gait_q    = mbdd_pkg::GAIT_TROT;
                                d.changed = 1'b1;
                            end
                        end
                        mbdd_pkg::BTN_TROT: begin
                            if (gait_q != mbdd_pkg::GAIT_TROT) begin
                                gait_q    = mbdd_pkg::GAIT_TROT;
                                d.changed = 1'b1;
                            end
                        end
                        mbdd_pkg::BTN_WALK: begin
                            if (gait_q != mbdd_pkg::GAIT_WALK) begin
                                gait_q    = mbdd_pkg::GAIT_WALK;
                                d.changed = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            raw_q[b] = lv[b];
        end
        d.stable = stable_q;
        d.zero   = (slot == mbdd_pkg::REQ_ZERO);
        d.raise  = (slot == mbdd_pkg::REQ_RAISE);
        d.lower  = (slot == mbdd_pkg::REQ_LOWER);
        d.wheel  = wheel_q;
        d.gait   = gait_q;
        return d;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s expected %0h got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_dispatch e;
        if (!i_rst_n) begin
            delay_q  = mbdd_pkg::DELAY_RESET;
            raw_q    = '0;
            stable_q = '0;
            wheel_q  = 1'b0;
            gait_q   = mbdd_pkg::GAIT_TROT;
            for (int b = 0; b < mbdd_pkg::BTN_W; b++) begin
                stamp_q[b] = '0;
            end
            expected_dispatch.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (expected_dispatch.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    e = expected_dispatch.pop_front();
                    check_field("press_events", 32'(e.press),
                                32'(i_result.press_events));
                    check_field("stable_levels", 32'(e.stable),
                                32'(i_result.stable_levels));
                    check_field("zero_request", 32'(e.zero),
                                32'(i_result.zero_request));
                    check_field("raise_request", 32'(e.raise),
                                32'(i_result.raise_request));
                    check_field("lower_request", 32'(e.lower),
                                32'(i_result.lower_request));
                    check_field("wheel_mode", 32'(e.wheel),
                                32'(i_result.wheel_mode));
                    check_field("gait_mode", 32'(e.gait),
                                32'(i_result.gait_mode));
                    check_field("gait_changed", 32'(e.changed),
                                32'(i_result.gait_changed));
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                expected_dispatch.push_back(
                    debounce_and_dispatch(i_sample.button_levels, i_sample.now_ms));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                delay_q = i_cfg.debounce_delay;
            end
        end
        o_pending <= expected_dispatch.size();
    end

endmodule

FILE: test/tb_multi_button_debounce_dispatch_core.sv
module tb_multi_button_debounce_dispatch_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 200;

    logic i_clk;
    logic i_rst_n;

    mbdd_in_if  smp_if ();
    mbdd_out_if res_if ();
    mbdd_cfg_if cfg_if ();

    int                         errors;
    int                         pending;
    logic                       quiet = 1'b0;
    logic                       long_hold = 1'b0;
    logic [mbdd_pkg::BTN_W-1:0] levels_q = '0;
    logic [mbdd_pkg::NOW_W-1:0] now_q = '0;
    logic [mbdd_pkg::NOW_W-1:0] delay_cur = 32'(mbdd_pkg::DELAY_RESET);
    int                         sent_count = 0;

    multi_button_debounce_dispatch_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    debounce_dispatch_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (smp_if),
        .i_result  (res_if),
        .i_cfg     (cfg_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #5_000_000;
        $display("tb_multi_button_debounce_dispatch_core: errors");
        $finish;
    end

    // result side: random ready bursts, one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (quiet) begin
                res_if.ready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic put_sample(input logic [mbdd_pkg::BTN_W-1:0] lv,
                              input logic [mbdd_pkg::NOW_W-1:0] ts);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        smp_if.valid         <= 1'b1;
        smp_if.button_levels <= lv;
        smp_if.now_ms        <= ts;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic drain();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_delay(input logic [mbdd_pkg::DELAY_W-1:0] d);
        drain();
        cfg_if.valid          <= 1'b1;
        cfg_if.debounce_delay <= d;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        delay_cur = 32'(d);
    endtask

    // bouncy edge toward a target pattern, then held until it settles
    task automatic button_episode();
        logic [mbdd_pkg::BTN_W-1:0] target;
        logic [mbdd_pkg::NOW_W-1:0] settle;
        case ($urandom_range(0, 3))
            0:       target = levels_q ^ (8'd1 << $urandom_range(0, 7));
            1:       target = 8'd1 << $urandom_range(0, 5);
            2:       target = '0;
            default: target = 8'($urandom_range(0, 255));
        endcase
        repeat ($urandom_range(0, 3)) begin
            now_q += $urandom_range(0, delay_cur / 4 + 1);
            put_sample(target ^ 8'($urandom_range(1, 255)), now_q);
        end
        now_q += $urandom_range(0, delay_cur / 4 + 1);
        put_sample(target, now_q);
        settle = now_q;
        if ($urandom_range(0, 3) == 0) begin
            put_sample(target, settle + delay_cur);
        end
        now_q = settle + delay_cur + 1 + $urandom_range(0, 3);
        put_sample(target, now_q);
        levels_q = target;
    endtask

    task automatic noise_sample();
        case ($urandom_range(0, 2))
            0:       now_q += $urandom_range(0, 3);
            1:       now_q = $urandom();
            default: now_q -= $urandom_range(1, 50);
        endcase
        levels_q = 8'($urandom_range(0, 255));
        put_sample(levels_q, now_q);
    endtask

    task automatic run_random(input int n);
        int goal;
        goal = sent_count + n;
        while (sent_count < goal) begin
            if ($urandom_range(0, 4) == 0) begin
                noise_sample();
            end else begin
                button_episode();
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        smp_if.valid          = 1'b0;
        smp_if.button_levels  = '0;
        smp_if.now_ms         = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.debounce_delay = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all at once: wheel on wins the request slot, walk after trot
        put_sample(8'hFF, 32'd100);
        put_sample(8'hFF, 32'd131);
        // release, first exactly at the delay
        put_sample(8'h00, 32'd140);
        put_sample(8'h00, 32'd170);
        put_sample(8'h00, 32'd171);
        // raise plus wheel off: raise stays, gait forced to trot
        put_sample(8'h0A, 32'd200);
        put_sample(8'h0A, 32'd231);
        put_sample(8'h00, 32'd240);
        put_sample(8'h00, 32'd271);
        // trot while trotting, then walk, then trot
        put_sample(8'h10, 32'd300);
        put_sample(8'h10, 32'd331);
        put_sample(8'h20, 32'd340);
        put_sample(8'h20, 32'd371);
        put_sample(8'h10, 32'd400);
        put_sample(8'h10, 32'd431);
        // timestamp wraps past zero
        put_sample(8'h01, 32'hFFFF_FFF0);
        put_sample(8'h01, 32'h0000_0010);
        // buttons without action, then time steps back
        put_sample(8'hC1, 32'h20);
        put_sample(8'hC1, 32'h40);
        put_sample(8'hC1, 32'h30);
        put_sample(8'h04, 32'h50);
        put_sample(8'h04, 32'h80);

        // zero delay: unchanged level taken once time moves on
        set_delay(16'd0);
        put_sample(8'h00, 32'h90);
        put_sample(8'h00, 32'h90);
        put_sample(8'h00, 32'h91);
        levels_q = '0;
        now_q    = 32'h91;
        run_random(150);

        set_delay(16'hFFFF);
        run_random(150);

        set_delay(16'($urandom_range(1, 100)));
        run_random(50);
        long_hold = 1'b1;
        run_random(200);

        set_delay(16'($urandom_range(0, 65535)));
        run_random(120);

        set_delay(mbdd_pkg::DELAY_RESET);
        run_random(130);
        quiet = 1'b1;
        run_random(120);

        drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_multi_button_debounce_dispatch_core: clean");
        end else begin
            $display("tb_multi_button_debounce_dispatch_core: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/mbdd_pkg.sv
rtl/core/mbdd_if.sv
rtl/core/mbdd_lane.sv
rtl/core/mbdd_merge.sv
rtl/core/multi_button_debounce_dispatch_core.sv
rtl/core/mbdd_checker.sv
test/debounce_dispatch_checker.sv
test/tb_multi_button_debounce_dispatch_core.sv
